/* rtl/core/srg_pkg.sv */
`timescale 1ns / 1ps

package srg_pkg;

  // table geometry and arithmetic constants
  localparam int TABLE_LEN   = 55;
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 30;
  localparam int SEED_W      = 28;
  localparam int LAG_GAP     = 31;
  localparam int FILL_STRIDE = 21;
  localparam int WARM_PASSES = 4;
  localparam int WARM_STEPS  = WARM_PASSES * TABLE_LEN;
  localparam int CNT_W       = 8;

  localparam logic [VAL_W-1:0]  MODULUS   = 30'd1000000000;
  localparam logic [SEED_W-1:0] SEED_BASE = 28'd161803398;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;

  // one write port and two read ports of the lag table
  typedef struct packed {
    logic we;
    idx_t waddr;
    val_t wdata;
    idx_t raddr_a;
    idx_t raddr_b;
  } mem_req_t;

  // one finished draw
  typedef struct packed {
    logic valid;
    val_t value;
  } res_t;

  // a - b wrapped into 0..MODULUS-1, both operands already below MODULUS
  function automatic val_t sub_mod(input val_t a, input val_t b);
    logic [VAL_W:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (diff[VAL_W]) begin
      sub_mod = diff[VAL_W-1:0] + MODULUS;
    end else begin
      sub_mod = diff[VAL_W-1:0];
    end
  endfunction

  // cyclic step through the table slots
  function automatic idx_t next_slot(input idx_t s);
    if (s == idx_t'(TABLE_LEN - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = s + idx_t'(1);
    end
  endfunction

endpackage

/* rtl/core/subtractive_random_generator.sv */
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+------------------------
// in       | in_valid / in_ready    | in_restart (1 bit)
// out      | out_valid / out_ready  | out_value (30 bits)
// cfg      | cfg_valid / cfg_ready  | cfg_seed (28 bits)
//
// An ordinary item does the lag table read, then the write-back of the lead slot.
// A seeding item (first after reset, or restart set) first adds a fill of all 55 slots and
// the warm-up passes, one table step a cycle through the single write port.
// Reset is synchronous, active low; seed resets to 76, the table is rebuilt on first use.
// A finished item waits in the output register; a new item is taken once the block is idle
// and that register is empty or being read.

module subtractive_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] out_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_seed
);
  import srg_pkg::*;

  logic [SEED_W-1:0] seed_r;
  logic              out_valid_r;
  val_t              out_value_r;
  mem_req_t          mem_req;
  val_t              rdata_a;
  val_t              rdata_b;
  res_t              res;
  logic              seq_idle;
  logic              in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 28'd76;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_seed;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r <= res.value;
    end
  end

  srg_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .restart (in_restart),
    .seed    (seed_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .req     (mem_req),
    .res     (res),
    .idle    (seq_idle)
  );

  srg_lag_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

`ifndef SYNTHESIS
  // a finished item never lands on an occupied output register
  assert property (@(posedge clk) disable iff (!rst_n) res.valid |-> !out_valid_r)
    else $error("result produced while output register full");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> !in_ready)
    else $error("item accepted while previous item in progress");

  // table writes stay inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (mem_req.waddr < IDX_W'(TABLE_LEN)))
    else $error("lag table write address out of range");

  // a result always lies below the modulus
  assert property (@(posedge clk) disable iff (!rst_n) res.valid |-> (res.value < MODULUS))
    else $error("result not reduced below modulus");
`endif

endmodule

/* rtl/core/srg_lag_mem.sv */
`timescale 1ns / 1ps

module srg_lag_mem (
  input  logic             clk,
  input  srg_pkg::mem_req_t req,
  output srg_pkg::val_t    rdata_a,
  output srg_pkg::val_t    rdata_b
);
  import srg_pkg::*;

  val_t mem [0:TABLE_LEN-1];

  // one write, two registered reads per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

/* rtl/core/srg_seq.sv */
`timescale 1ns / 1ps

module srg_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              restart,
  input  logic [27:0]       seed,
  input  srg_pkg::val_t     rdata_a,
  input  srg_pkg::val_t     rdata_b,
  output srg_pkg::mem_req_t req,
  output srg_pkg::res_t     res,
  output logic              idle
);
  import srg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_WARM = 2'd2;
  localparam logic [1:0] ST_DRAW = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  idx_t             pos_r, pos_nxt;
  val_t             prev_r, prev_nxt;
  val_t             cur_r, cur_nxt;
  idx_t             wi_r, wi_nxt;
  idx_t             wo_r, wo_nxt;
  logic             pend_r, pend_nxt;
  idx_t             wa_r, wa_nxt;
  idx_t             lead_r, lead_nxt;
  idx_t             trail_r, trail_nxt;
  logic             seeded_r, seeded_nxt;

  logic [SEED_W-1:0] seed_sat;
  logic [IDX_W:0]    pos_sum;
  val_t              rd_diff;

  assign seed_sat = (seed > SEED_BASE) ? SEED_BASE : seed;
  assign pos_sum  = {1'b0, pos_r} + (IDX_W + 1)'(FILL_STRIDE);
  assign rd_diff  = sub_mod(rdata_a, rdata_b);
  assign idle     = (state_r == ST_IDLE);

  // sequencer: seeding fill, warm-up passes and draws
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    wi_nxt     = wi_r;
    wo_nxt     = wo_r;
    pend_nxt   = pend_r;
    wa_nxt     = wa_r;
    lead_nxt   = lead_r;
    trail_nxt  = trail_r;
    seeded_nxt = seeded_r;
    req        = '0;
    res        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (restart || !seeded_r) begin
            state_nxt = ST_FILL;
            cnt_nxt   = '0;
            pos_nxt   = '0;
            prev_nxt  = VAL_W'(SEED_BASE - seed_sat);
            cur_nxt   = VAL_W'(1);
          end else begin
            state_nxt   = ST_DRAW;
            lead_nxt    = next_slot(lead_r);
            trail_nxt   = next_slot(trail_r);
            req.raddr_a = lead_nxt;
            req.raddr_b = trail_nxt;
          end
        end
      end

      ST_FILL: begin
        // scattered fill, stride 21, one slot a cycle
        req.we    = 1'b1;
        req.waddr = (pos_r == '0) ? idx_t'(TABLE_LEN - 1) : pos_r - idx_t'(1);
        if (cnt_r == '0) begin
          req.wdata = prev_r;
        end else begin
          req.wdata = cur_r;
          prev_nxt  = cur_r;
          cur_nxt   = sub_mod(prev_r, cur_r);
        end
        if (pos_sum >= (IDX_W + 1)'(TABLE_LEN)) begin
          pos_nxt = idx_t'(pos_sum - (IDX_W + 1)'(TABLE_LEN));
        end else begin
          pos_nxt = idx_t'(pos_sum);
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TABLE_LEN - 1)) begin
          state_nxt = ST_WARM;
          cnt_nxt   = '0;
          wi_nxt    = '0;
          wo_nxt    = idx_t'(LAG_GAP);
          pend_nxt  = 1'b0;
        end
      end

      ST_WARM: begin
        // read slot i and i+31, write slot i back in the following cycle
        if (pend_r) begin
          req.we    = 1'b1;
          req.waddr = wa_r;
          req.wdata = rd_diff;
        end
        if (cnt_r < CNT_W'(WARM_STEPS)) begin
          req.raddr_a = wi_r;
          req.raddr_b = wo_r;
          pend_nxt    = 1'b1;
          wa_nxt      = wi_r;
          wi_nxt      = next_slot(wi_r);
          wo_nxt      = next_slot(wo_r);
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          // last write goes out; first draw reads slots 0 and 31
          pend_nxt    = 1'b0;
          seeded_nxt  = 1'b1;
          lead_nxt    = '0;
          trail_nxt   = idx_t'(LAG_GAP);
          req.raddr_a = lead_nxt;
          req.raddr_b = trail_nxt;
          state_nxt   = ST_DRAW;
        end
      end

      ST_DRAW: begin
        // difference goes back into the lead slot and out as the result
        req.we    = 1'b1;
        req.waddr = lead_r;
        req.wdata = rd_diff;
        res.valid = 1'b1;
        res.value = rd_diff;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      seeded_r <= 1'b0;
      lead_r   <= '0;
      trail_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      seeded_r <= seeded_nxt;
      lead_r   <= lead_nxt;
      trail_r  <= trail_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    wi_r   <= wi_nxt;
    wo_r   <= wo_nxt;
    wa_r   <= wa_nxt;
  end

endmodule

/* tb/tb_subtractive_random_generator.sv */
`timescale 1ns / 1ps

module tb_subtractive_random_generator;
  import srg_pkg::*;

  localparam int unsigned MOD_VAL  = MODULUS;
  localparam int unsigned BASE_VAL = SEED_BASE;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          PHASES       = 8;
  localparam int          HOLD_AT      = 370;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DIR_ROWS     = 17;

  typedef struct {
    bit          write_seed;
    logic [27:0] seed;
    logic        restart;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_restart;
  logic        out_valid;
  logic        out_ready;
  logic [29:0] out_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [27:0] cfg_seed;

  // model state of the generator
  int unsigned lag_model [TABLE_LEN];
  int          lead_slot;
  int          trail_slot;
  bit          model_seeded;
  logic [27:0] seed_shadow;

  val_t        expected_values [$];
  int          mismatches;
  int          results_seen;
  bit          held_off;
  dir_row_t    dir_rows [DIR_ROWS];

  subtractive_random_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed)
  );

  // clock, period 2 ns
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // wrapped difference of two words below the modulus
  function automatic int unsigned wrap_sub(input int unsigned a, input int unsigned b);
    return (a >= b) ? (a - b) : (a + MOD_VAL - b);
  endfunction

  // scattered fill from the seed, then warm-up passes
  function automatic void rebuild_lag_table();
    int unsigned s;
    int unsigned prev;
    int unsigned cur;
    int unsigned nxt;
    int unsigned slot;
    s = (seed_shadow > BASE_VAL) ? BASE_VAL : seed_shadow;
    prev = BASE_VAL - s;
    cur = 1;
    lag_model[TABLE_LEN-1] = prev;
    for (int i = 1; i < TABLE_LEN; i++) begin
      slot = ((FILL_STRIDE * i) % TABLE_LEN + TABLE_LEN - 1) % TABLE_LEN;
      lag_model[slot] = cur;
      nxt = wrap_sub(prev, cur);
      prev = cur;
      cur = nxt;
    end
    for (int p = 0; p < WARM_PASSES; p++) begin
      for (int i = 0; i < TABLE_LEN; i++) begin
        lag_model[i] = wrap_sub(lag_model[i], lag_model[(i + LAG_GAP) % TABLE_LEN]);
      end
    end
    lead_slot = TABLE_LEN - 1;
    trail_slot = LAG_GAP - 1;
    model_seeded = 1'b1;
  endfunction

  // one draw: step both slots, subtract, write back
  function automatic val_t next_random_value(input logic restart);
    int unsigned d;
    if (restart || !model_seeded) begin
      rebuild_lag_table();
    end
    lead_slot = (lead_slot == TABLE_LEN - 1) ? 0 : lead_slot + 1;
    trail_slot = (trail_slot == TABLE_LEN - 1) ? 0 : trail_slot + 1;
    d = wrap_sub(lag_model[lead_slot], lag_model[trail_slot]);
    lag_model[lead_slot] = d;
    return val_t'(d);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // track accepted items and seed writes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_values.push_back(next_random_value(in_restart));
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      seed_shadow = cfg_seed;
    end
  end

  // compare each result with the oldest expected value
  always @(posedge clk) begin
    val_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: value=%0d", out_value);
        end
      end else begin
        want = expected_values.pop_front();
        if (out_value !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("value mismatch: expected=%0d actual=%0d", want, out_value);
          end
        end
      end
    end
  end

  // result side: random ready pattern, one long hold-off under load
  initial begin
    int len;
    int r;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 70) begin
          out_ready <= 1'b1;
          len = 100;
        end else begin
          out_ready <= 1'b0;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item after a gap; called and returns at a falling edge
  task automatic offer_item(input logic restart, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait until every expected item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [27:0] value);
    cfg_valid <= 1'b1;
    cfg_seed <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    logic [27:0] seed_val;
    bit          no_gaps;
    int          per_phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    cfg_valid = 1'b0;
    cfg_seed = '0;
    mismatches = 0;
    results_seen = 0;
    held_off = 1'b0;
    model_seeded = 1'b0;
    lead_slot = 0;
    trail_slot = 0;
    seed_shadow = 28'd76;
    foreach (lag_model[i]) lag_model[i] = 0;

    // directed rows: seed extremes, saturation, restart before first draw
    dir_rows = '{
      '{1'b0, 28'd0,         1'b1},
      '{1'b0, 28'd0,         1'b0},
      '{1'b0, 28'd0,         1'b0},
      '{1'b0, 28'd0,         1'b1},
      '{1'b0, 28'd0,         1'b0},
      '{1'b1, 28'd0,         1'b1},
      '{1'b0, 28'd0,         1'b0},
      '{1'b1, 28'd161803398, 1'b1},
      '{1'b0, 28'd0,         1'b0},
      '{1'b1, 28'hFFFFFFF,   1'b1},
      '{1'b0, 28'd0,         1'b0},
      '{1'b1, 28'd161803399, 1'b1},
      '{1'b1, 28'd1,         1'b0},
      '{1'b0, 28'd0,         1'b0},
      '{1'b0, 28'd0,         1'b1},
      '{1'b1, 28'h5555555,   1'b1},
      '{1'b1, 28'hAAAAAAA,   1'b1}
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].write_seed) begin
        wait_drained();
        write_seed(dir_rows[i].seed);
      end
      offer_item(dir_rows[i].restart, pick_gap());
    end

    // random phases, each under its own seed
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: seed_val = 28'd0;
        1: seed_val = SEED_BASE;
        2: seed_val = 28'hFFFFFFF;
        default: begin
          if ($urandom_range(0, 1) == 0) seed_val = 28'($urandom);
          else seed_val = 28'($urandom_range(0, BASE_VAL));
        end
      endcase
      write_seed(seed_val);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_phase; n++) begin
        offer_item((n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0),
                   no_gaps ? 0 : pick_gap());
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/srg_pkg.sv
rtl/core/srg_lag_mem.sv
rtl/core/srg_seq.sv
rtl/core/subtractive_random_generator.sv
tb/tb_subtractive_random_generator.sv
